// File: rtl/core/xmt_pkg.sv
// shared types, character constants and helpers for the xml markup event tokenizer
package xmt_pkg;

    // parse modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE        = 5'b00001,
        MODE_TEXT        = 5'b00010,
        MODE_MARKUP      = 5'b00100,
        MODE_COMMENT_RUN = 5'b01000,
        MODE_CDATA_RUN   = 5'b10000
    } xmt_mode_t;

    // event codes
    localparam logic [3:0] EV_DECL       = 4'd0;
    localparam logic [3:0] EV_DOCTYPE    = 4'd1;
    localparam logic [3:0] EV_BEGIN      = 4'd2;
    localparam logic [3:0] EV_END        = 4'd3;
    localparam logic [3:0] EV_EMPTY      = 4'd4;
    localparam logic [3:0] EV_COMMENT    = 4'd5;
    localparam logic [3:0] EV_CDATA      = 4'd6;
    localparam logic [3:0] EV_TEXT       = 4'd7;
    localparam logic [3:0] EV_UNBALANCED = 4'd8;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // markup prefixes, letters in lower case for folded compare
    localparam logic [7:0] DECL_STR    [0:3] = '{"?", "x", "m", "l"};
    localparam logic [7:0] DOCTYPE_STR [0:7] = '{"!", "d", "o", "c", "t", "y", "p", "e"};
    localparam logic [7:0] COMMENT_STR [0:2] = '{"!", "-", "-"};
    localparam logic [7:0] CDATA_STR   [0:7] = '{"!", "[", "c", "d", "a", "t", "a", "["};

    // per-item parse context
    typedef struct packed {
        xmt_mode_t   mode;
        logic [63:0] prefix;        // first eight content bytes, byte 0 lowest
        logic [15:0] last_two;      // last two content bytes, newest lowest
        logic [1:0]  closer_run;    // run of '-' or ']' in a run-on, saturates at 3
        logic [1:0]  newline_match; // 1: text is cr so far, 2: text is lf or cr lf
    } xmt_ctx_t;

    // event produced by one byte
    typedef struct packed {
        logic       valid;
        logic [3:0] code;
    } xmt_event_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/xml_markup_event_tokenizer.sv
// top level of the xml markup event tokenizer: input register, parse state, result register
//
// usage
//   s_ channel: one document byte per request. s_tdata[7:0] is the byte, a zero byte
//   ends the stream and drops any partial item. s_tuser[0] is restart: it clears the
//   nesting depth and parse state, the byte is ignored and no event comes out.
//   m_ channel: one request per finished markup item or text run, none for a text run
//   that is only lf or cr lf. m_tuser[3:0] is the event code, m_tdata[15:0] the nesting
//   depth after the event, m_tdata[31:16] the content length, both clamped to 65535.
// timing
//   one byte per cycle sustained while no event waits on a full result register. a byte
//   taken is parsed out of the input register, and its event goes into the result register.
//   the parse itself is one pass of compare logic on the byte and the stored context.
// reset
//   aresetn low clears both valid flags, the depth and the parse state (idle).
// stall
//   while the result register holds an event that is not taken, bytes that cause no
//   event still move through; a byte that would cause an event waits in the input
//   register, and s_tready falls until the result register frees.
module xml_markup_event_tokenizer
    import xmt_pkg::*;
#(
    parameter int DEPTH_BITS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] restart
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] depth_after, [31:16] content_length
    output logic [3:0]  m_tuser    // [3:0] event_code
);

    // input register
    logic                   in_vld_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_restart_reg;

    // parse state
    xmt_ctx_t               ctx_reg, ctx_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    // result register
    logic                   out_vld_reg;
    logic [3:0]             out_code_reg;
    logic [15:0]            out_depth_reg;
    logic [15:0]            out_len_reg;

    xmt_event_t             ev;
    logic [15:0]            ev_depth;
    logic [15:0]            ev_len;
    logic                   out_free;
    logic                   proc;
    logic                   s_fire;

    xmt_step #(
        .DEPTH_BITS  (DEPTH_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .data_byte  (in_byte_reg),
        .restart    (in_restart_reg),
        .ctx        (ctx_reg),
        .depth      (depth_reg),
        .len        (len_reg),
        .ctx_next   (ctx_next),
        .depth_next (depth_next),
        .len_next   (len_next),
        .ev         (ev),
        .ev_depth   (ev_depth),
        .ev_len     (ev_len)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_vld_reg || m_tready;
    // a byte that raises no event never waits on the result side
    assign proc     = in_vld_reg && (out_free || !ev.valid);
    assign s_tready = !in_vld_reg || proc;
    assign s_fire   = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_fire) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser[0];
        end
    end

    // parse state, advanced once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg   <= '{mode: MODE_IDLE, default: '0};
            depth_reg <= '0;
            len_reg   <= '0;
        end else if (proc) begin
            ctx_reg   <= ctx_next;
            depth_reg <= depth_next;
            len_reg   <= len_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc && ev.valid) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (proc && ev.valid) begin
            out_code_reg  <= ev.code;
            out_depth_reg <= ev_depth;
            out_len_reg   <= ev_len;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_code_reg;
    assign m_tdata  = {out_len_reg, out_depth_reg};

endmodule

// File: rtl/core/xmt_step.sv
// next-state and event logic for one document byte
module xmt_step
    import xmt_pkg::*;
#(
    parameter int DEPTH_BITS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic [7:0]             data_byte,
    input  logic                   restart,
    input  xmt_ctx_t               ctx,
    input  logic [DEPTH_BITS-1:0]  depth,
    input  logic [LENGTH_BITS-1:0] len,
    output xmt_ctx_t               ctx_next,
    output logic [DEPTH_BITS-1:0]  depth_next,
    output logic [LENGTH_BITS-1:0] len_next,
    output xmt_event_t             ev,
    output logic [15:0]            ev_depth,
    output logic [15:0]            ev_len
);

    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = {DEPTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

    logic [7:0]             pb [0:7];
    logic [7:0]             pl [0:7];
    logic [7:0]             last_b;
    logic [7:0]             prev_b;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [LENGTH_BITS-1:0] ev_len_full;
    logic                   decl_hit, doct_hit, comm_hit, cdat_hit;
    logic [7:0]             closer;
    logic [3:0]             run_code;
    logic [32:0]            depth_wide;
    logic [32:0]            len_wide;
    xmt_ctx_t               ctx_clear;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pb[i] = ctx.prefix[i*8 +: 8];
            pl[i] = lower_ascii(pb[i]);
        end
    end

    assign last_b  = ctx.last_two[7:0];
    assign prev_b  = ctx.last_two[15:8];
    assign len_inc = (len == LENGTH_MAX) ? len : len + 1'b1;

    // prefix matches, qualified by item size
    always_comb begin
        decl_hit = (len > LENGTH_BITS'(4));
        for (int i = 0; i < 4; i++) begin
            decl_hit = decl_hit && (pl[i] == DECL_STR[i]);
        end
        doct_hit = (len > LENGTH_BITS'(8));
        for (int i = 0; i < 8; i++) begin
            doct_hit = doct_hit && (pl[i] == DOCTYPE_STR[i]);
        end
        comm_hit = (len >= LENGTH_BITS'(3));
        for (int i = 0; i < 3; i++) begin
            comm_hit = comm_hit && (pb[i] == COMMENT_STR[i]);
        end
        cdat_hit = (len >= LENGTH_BITS'(8));
        for (int i = 0; i < 8; i++) begin
            cdat_hit = cdat_hit && (pl[i] == CDATA_STR[i]);
        end
    end

    assign closer   = (ctx.mode == MODE_COMMENT_RUN) ? CH_DASH : CH_RBRACK;
    assign run_code = (ctx.mode == MODE_COMMENT_RUN) ? EV_COMMENT : EV_CDATA;

    always_comb begin
        ctx_clear               = '0;
        ctx_clear.mode          = MODE_IDLE;
    end

    always_comb begin
        ctx_next    = ctx;
        depth_next  = depth;
        len_next    = len;
        ev.valid    = 1'b0;
        ev.code     = EV_TEXT;
        ev_len_full = len;

        if (restart) begin
            ctx_next   = ctx_clear;
            depth_next = '0;
            len_next   = '0;
        end else if (data_byte == CH_NUL) begin
            ctx_next = ctx_clear;
            len_next = '0;
        end else begin
            unique case (ctx.mode)
                MODE_TEXT: begin
                    if (data_byte == CH_LT) begin
                        ev.valid      = (ctx.newline_match != 2'd2);
                        ev.code       = EV_TEXT;
                        ctx_next      = ctx_clear;
                        ctx_next.mode = MODE_MARKUP;
                        len_next      = '0;
                    end else begin
                        len_next = len_inc;
                        ctx_next.newline_match =
                            (ctx.newline_match == 2'd1 && data_byte == CH_LF) ? 2'd2 : 2'd0;
                    end
                end
                MODE_MARKUP: begin
                    if (data_byte == CH_GT) begin
                        ctx_next.mode = MODE_IDLE;
                        ev.valid      = 1'b1;
                        if (decl_hit) begin
                            ev.code = EV_DECL;
                        end else if (doct_hit) begin
                            ev.code = EV_DOCTYPE;
                        end else if (len > LENGTH_BITS'(1) && pb[0] == CH_SLASH) begin
                            if (depth == '0) begin
                                ev.code = EV_UNBALANCED;
                            end else begin
                                ev.code    = EV_END;
                                depth_next = depth - 1'b1;
                            end
                        end else if (comm_hit) begin
                            if (prev_b == CH_DASH && last_b == CH_DASH) begin
                                ev.code = EV_COMMENT;
                            end else begin
                                ev.valid            = 1'b0;
                                len_next            = len_inc;
                                ctx_next.closer_run = 2'd0;
                                ctx_next.mode       = MODE_COMMENT_RUN;
                            end
                        end else if (cdat_hit) begin
                            if (prev_b == CH_RBRACK && last_b == CH_RBRACK) begin
                                ev.code = EV_CDATA;
                            end else begin
                                ev.valid            = 1'b0;
                                len_next            = len_inc;
                                ctx_next.closer_run = 2'd0;
                                ctx_next.mode       = MODE_CDATA_RUN;
                            end
                        end else if (len > LENGTH_BITS'(1) && last_b == CH_SLASH) begin
                            ev.code = EV_EMPTY;
                        end else begin
                            ev.code = EV_BEGIN;
                            if (depth != DEPTH_MAX) begin
                                depth_next = depth + 1'b1;
                            end
                        end
                    end else begin
                        if (len < LENGTH_BITS'(8)) begin
                            ctx_next.prefix[len[2:0]*8 +: 8] = pb[len[2:0]] | data_byte;
                        end
                        len_next          = len_inc;
                        ctx_next.last_two = {ctx.last_two[7:0], data_byte};
                    end
                end
                MODE_COMMENT_RUN, MODE_CDATA_RUN: begin
                    if (ctx.closer_run == 2'd2 && data_byte == CH_GT) begin
                        ctx_next.mode = MODE_IDLE;
                        ev.valid      = 1'b1;
                        ev.code       = run_code;
                    end else begin
                        len_next = len_inc;
                        if (data_byte == closer) begin
                            ctx_next.closer_run =
                                (ctx.closer_run == 2'd3) ? 2'd3 : ctx.closer_run + 2'd1;
                        end else begin
                            ctx_next.closer_run = 2'd0;
                        end
                    end
                end
                default: begin
                    ctx_next = ctx_clear;
                    if (data_byte == CH_LT) begin
                        ctx_next.mode = MODE_MARKUP;
                        len_next      = '0;
                    end else begin
                        ctx_next.mode = MODE_TEXT;
                        len_next      = LENGTH_BITS'(1);
                        ctx_next.newline_match = (data_byte == CH_LF) ? 2'd2 :
                                                 (data_byte == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
            endcase
        end
    end

    // clamp reported values to 16 bits
    assign depth_wide = {{(33-DEPTH_BITS){1'b0}}, depth_next};
    assign len_wide   = {{(33-LENGTH_BITS){1'b0}}, ev_len_full};
    assign ev_depth   = (depth_wide > 33'h0FFFF) ? 16'hFFFF : depth_wide[15:0];
    assign ev_len     = (len_wide > 33'h0FFFF) ? 16'hFFFF : len_wide[15:0];

endmodule

// File: rtl/core/xmt_checker.sv
// port-level checks for the xml markup event tokenizer, bound to the top level
module xmt_checker
    import xmt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // a stalled event stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled event changed");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("event valid after reset");

    // only defined event codes
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= EV_UNBALANCED)
        else $error("undefined event code");

    // an unbalanced end tag leaves depth at zero
    a_unbal_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_UNBALANCED |-> m_tdata[15:0] == 16'd0)
        else $error("unbalanced end with nonzero depth");

    // a begin tag always leaves depth above zero
    a_begin_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_BEGIN |-> m_tdata[15:0] != 16'd0)
        else $error("begin tag with zero depth");

endmodule

bind xml_markup_event_tokenizer xmt_checker u_xmt_checker (.*);

// File: sim/tb_xml_markup_event_tokenizer.sv
// self-checking testbench for the xml markup event tokenizer: directed documents, random streams
`timescale 1ns / 100ps

module tb_xml_markup_event_tokenizer;
    import xmt_pkg::*;

    // one finished markup item or text run as the result channel shows it
    typedef struct {
        logic [3:0]  ev_code;
        logic [15:0] depth;
        logic [15:0] size;
    } markup_event_t;

    localparam logic [15:0] DEPTH_LIMIT  = 16'hFFFF;
    localparam logic [15:0] LENGTH_LIMIT = 16'hFFFF;

    // clock, reset and block ports
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
    logic [0:0]  s_tuser  = 1'b0;   // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [15:0] depth_after, [31:16] content_length
    logic [3:0]  m_tuser;           // [3:0] event_code

    // predicted parse state of the document
    xmt_mode_t   doc_mode     = MODE_IDLE;
    logic [15:0] doc_depth    = '0;
    logic [15:0] item_len     = '0;
    logic [63:0] head_bytes   = '0;  // first eight content bytes, byte 0 lowest
    logic [15:0] last_pair    = '0;  // last two content bytes, newest lowest
    logic [1:0]  closer_count = '0;  // run of '-' or ']' inside a run-on
    logic [1:0]  crlf_state   = '0;  // 1: text is cr so far, 2: text is lf or cr lf

    // events still owed by the block, oldest first
    markup_event_t pending_events[$];

    int unsigned mismatches   = 0;
    int unsigned bytes_sent   = 0;
    bit          steady       = 1'b0;  // no gaps and no stalls on either side
    bit          result_taken = 1'b0;  // set by the checker, consumed by the receiver
    int unsigned hold_cycles  = 0;     // long receiver hold-off, requested by a test
    int unsigned stall_left   = 0;

    xml_markup_event_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // event prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    // compare the leading content bytes with a keyword, optionally ignoring letter case
    function automatic bit head_matches(input string word, input bit fold);
        logic [7:0] a;
        logic [7:0] b;
        for (int i = 0; i < word.len(); i++) begin
            a = head_bytes[i*8 +: 8];
            b = word[i];
            if (fold) begin
                a = fold_case(a);
                b = fold_case(b);
            end
            if (a != b) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void owe_event(input logic [3:0] code, input logic [15:0] n);
        markup_event_t ev;
        ev.ev_code = code;
        ev.depth   = doc_depth;
        ev.size    = n;
        pending_events.push_back(ev);
    endfunction

    function automatic void grow_item();
        if (item_len != LENGTH_LIMIT) begin
            item_len++;
        end
    endfunction

    function automatic void clear_item();
        item_len     = '0;
        head_bytes   = '0;
        last_pair    = '0;
        closer_count = '0;
        crlf_state   = '0;
    endfunction

    // the '>' that ends markup content: classify in priority order
    function automatic void close_markup();
        logic [15:0] n;
        logic [7:0]  last;
        logic [7:0]  prev;
        n    = item_len;
        last = last_pair[7:0];
        prev = last_pair[15:8];
        doc_mode = MODE_IDLE;
        if (n > 4 && head_matches("?xml", 1'b1)) begin
            owe_event(EV_DECL, n);
        end else if (n > 8 && head_matches("!doctype", 1'b1)) begin
            owe_event(EV_DOCTYPE, n);
        end else if (n > 1 && head_bytes[7:0] == CH_SLASH) begin
            if (doc_depth == 0) begin
                owe_event(EV_UNBALANCED, n);
            end else begin
                doc_depth--;
                owe_event(EV_END, n);
            end
        end else if (n >= 3 && head_matches("!--", 1'b0)) begin
            if (prev == CH_DASH && last == CH_DASH) begin
                owe_event(EV_COMMENT, n);
            end else begin
                // not closed yet: this '>' is content of a run-on comment
                grow_item();
                closer_count = '0;
                doc_mode = MODE_COMMENT_RUN;
            end
        end else if (n >= 8 && head_matches("![cdata[", 1'b1)) begin
            if (prev == CH_RBRACK && last == CH_RBRACK) begin
                owe_event(EV_CDATA, n);
            end else begin
                grow_item();
                closer_count = '0;
                doc_mode = MODE_CDATA_RUN;
            end
        end else if (n > 1 && last == CH_SLASH) begin
            owe_event(EV_EMPTY, n);
        end else begin
            if (doc_depth != DEPTH_LIMIT) begin
                doc_depth++;
            end
            owe_event(EV_BEGIN, n);
        end
    endfunction

    // advance the predicted parse by one accepted request
    function automatic void tokenize_byte(input logic [7:0] b, input bit restart);
        logic [15:0] n;
        logic [7:0]  closer;
        logic [3:0]  code;
        if (restart) begin
            doc_mode  = MODE_IDLE;
            doc_depth = '0;
            clear_item();
            return;
        end
        if (b == CH_NUL) begin
            // end of stream drops the partial item, depth is kept
            doc_mode = MODE_IDLE;
            clear_item();
            return;
        end
        case (doc_mode)
            MODE_TEXT: begin
                if (b == CH_LT) begin
                    // the '<' ends the text and opens markup
                    n = item_len;
                    code = (crlf_state != 2'd2) ? EV_TEXT : EV_DECL;
                    clear_item();
                    doc_mode = MODE_MARKUP;
                    if (code == EV_TEXT) begin
                        owe_event(EV_TEXT, n);
                    end
                end else begin
                    grow_item();
                    crlf_state = (crlf_state == 2'd1 && b == CH_LF) ? 2'd2 : 2'd0;
                end
            end
            MODE_MARKUP: begin
                if (b == CH_GT) begin
                    close_markup();
                end else begin
                    if (item_len < 8) begin
                        head_bytes[item_len*8 +: 8] = b;
                    end
                    grow_item();
                    last_pair = {last_pair[7:0], b};
                end
            end
            MODE_COMMENT_RUN, MODE_CDATA_RUN: begin
                closer = (doc_mode == MODE_COMMENT_RUN) ? CH_DASH : CH_RBRACK;
                code   = (doc_mode == MODE_COMMENT_RUN) ? EV_COMMENT : EV_CDATA;
                if (closer_count == 2'd2 && b == CH_GT) begin
                    doc_mode = MODE_IDLE;
                    owe_event(code, item_len);
                end else begin
                    grow_item();
                    if (b == closer) begin
                        closer_count = (closer_count == 2'd3) ? 2'd3 : closer_count + 2'd1;
                    end else begin
                        closer_count = '0;
                    end
                end
            end
            default: begin
                clear_item();
                if (b == CH_LT) begin
                    doc_mode = MODE_MARKUP;
                end else begin
                    doc_mode   = MODE_TEXT;
                    item_len   = 16'd1;
                    crlf_state = (b == CH_LF) ? 2'd2 : (b == CH_CR) ? 2'd1 : 2'd0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------

    // offer one byte after a random gap, predict on acceptance
    task automatic send_byte(input logic [7:0] b, input bit restart = 1'b0);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart;
        @(posedge aclk);
        while (s_tready !== 1'b1) begin
            @(posedge aclk);
        end
        tokenize_byte(b, restart);
        bytes_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic idle_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: receiver stalls and checker
    // ------------------------------------------------------------------

    // ready drawn per result; a requested hold-off is counted down here
    always @(negedge aclk) begin
        if (hold_cycles != 0) begin
            stall_left   = hold_cycles;
            hold_cycles  = 0;
            result_taken = 1'b0;
        end else if (result_taken) begin
            stall_left   = steady ? 0 : $urandom_range(0, 8);
            result_taken = 1'b0;
        end
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        markup_event_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            result_taken = 1'b1;
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected result", {m_tdata[31:4], m_tuser}, '0);
            end else begin
                want = pending_events.pop_front();
                if (m_tuser !== want.ev_code) begin
                    report_mismatch("event_code", 32'(m_tuser), 32'(want.ev_code));
                end
                if (m_tdata[15:0] !== want.depth) begin
                    report_mismatch("depth_after", 32'(m_tdata[15:0]), 32'(want.depth));
                end
                if (m_tdata[31:16] !== want.size) begin
                    report_mismatch("content_length", 32'(m_tdata[31:16]), 32'(want.size));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // random content helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'("a") + 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? (c & 8'hDF) : c;
    endfunction

    // body bytes of comments, cdata and attributes: closers and '>' show up often
    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 9))
            0:       return CH_DASH;
            1:       return CH_RBRACK;
            2:       return CH_GT;
            3:       return CH_SLASH;
            4:       return CH_LT;
            5:       return 8'($urandom_range(1, 255));
            default: return random_letter();
        endcase
    endfunction

    function automatic string mix_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++) begin
            if (fold_case(r[i]) >= "a" && fold_case(r[i]) <= "z" && $urandom_range(0, 1)) begin
                r[i] = r[i] ^ 8'h20;
            end
        end
        return r;
    endfunction

    task automatic send_name();
        repeat ($urandom_range(1, 6)) begin
            send_byte(random_letter());
        end
    endtask

    task automatic send_body(input int unsigned most);
        repeat ($urandom_range(0, most)) begin
            send_byte(body_byte());
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every event kind but text, keyword case folding and the shortest markup forms
    task automatic test_markup_kinds();
        send_string("<?xml v?><!DOCTYPE d><a><b/><!--c--><![CDATA[x]]></a></a>");
        // empty content and a bare slash are begin tags
        send_string("<></>");
        // keyword too short for a declaration or doctype
        send_string("<?XmL><!doctype>");
        send_string("<?XML a?><!dOcTyPe e><![cdata[]]>");
        // '<' inside markup is content
        send_string("<a<b>");
    endtask

    // text runs, the newline-only forms and text with '>'
    task automatic test_text_runs();
        send_string("ab<x/>a>b<x/>");
        send_byte(CH_LF);
        send_string("<x/>");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_string("<x/>");
        send_byte(CH_CR);
        send_string("<x/>");
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_string("<x/>");
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_string("<x/>");
    endtask

    // comments and cdata that run past their first '>', and closer runs of three
    task automatic test_run_on();
        send_string("<!-- a > b -->");
        send_string("<!-- > --->x-->");
        send_string("<![CDATA[a>]]]>]]>");
        send_string("<![Cdata[>]]>");
    endtask

    // nul drops partial markup, text and run-ons, depth is kept
    task automatic test_stream_end();
        send_string("<abc");
        send_byte(CH_NUL);
        send_string("d>e");
        send_byte(CH_NUL);
        send_string("<!-- >");
        send_byte(CH_NUL);
        send_string("--><q/>");
    endtask

    // restart in the middle of markup clears the depth too
    task automatic test_restart();
        send_string("<a><b><c");
        send_byte(CH_GT, 1'b1);
        send_string("</a>");
        send_string("<d><e");
        send_byte(CH_NUL, 1'b1);
        send_string("></d>");
    endtask

    // receiver holds off long while the sender keeps going, so the block stalls its input
    task automatic test_back_pressure();
        steady      = 1'b1;
        hold_cycles = 300;
        repeat (40) begin
            send_string("<t/>");
        end
        steady = 1'b0;
    endtask

    // mostly well-formed items with random content, some noise and broken items
    task automatic test_random_documents();
        int unsigned stop_at;
        logic [7:0]  b;
        stop_at = bytes_sent + 1200;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                steady = !steady;
            end
            case ($urandom_range(0, 15))
                0, 1, 2, 3: begin
                    send_byte(CH_LT);
                    send_name();
                    if ($urandom_range(0, 3) == 0) begin
                        send_byte(" ");
                        send_name();
                    end
                    send_byte(CH_GT);
                end
                4, 5: begin
                    send_string("</");
                    send_name();
                    send_byte(CH_GT);
                end
                6: begin
                    send_byte(CH_LT);
                    send_name();
                    send_string("/>");
                end
                7: begin
                    send_string("<!--");
                    send_body(8);
                    send_string("-->");
                end
                8: begin
                    send_byte(CH_LT);
                    send_string(mix_case("![cdata["));
                    send_body(8);
                    send_string("]]>");
                end
                9: begin
                    send_byte(CH_LT);
                    send_string(mix_case($urandom_range(0, 1) ? "?xml " : "!doctype "));
                    send_name();
                    send_string("?>");
                end
                10, 11: begin
                    repeat ($urandom_range(1, 10)) begin
                        do begin
                            b = $urandom_range(0, 1) ? random_letter() : 8'($urandom_range(1, 255));
                        end while (b == CH_LT);
                        send_byte(b);
                    end
                end
                12: begin
                    case ($urandom_range(0, 3))
                        0: send_byte(CH_LF);
                        1: begin
                            send_byte(CH_CR);
                            send_byte(CH_LF);
                        end
                        2: send_byte(CH_CR);
                        default: begin
                            send_byte(CH_LF);
                            send_byte(CH_LF);
                        end
                    endcase
                end
                13: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
                14: begin
                    // item cut short by end of stream
                    send_byte(CH_LT);
                    send_name();
                    send_byte(CH_NUL);
                end
                default: begin
                    if ($urandom_range(0, 1)) begin
                        send_byte(8'($urandom_range(0, 255)), 1'b1);
                    end else begin
                        send_byte(CH_NUL);
                    end
                end
            endcase
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        // reset held low from time zero, released on a falling edge
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_markup_kinds();
        test_text_runs();
        test_run_on();
        test_stream_end();
        test_restart();
        test_back_pressure();
        test_random_documents();
        idle_sender();

        // drain, then let the pipeline settle
        while (pending_events.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
